>>> rtl/mtu_pkg.sv
// Package with the shared types and constants of the membership table update block.
package mtu_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam int unsigned AddrW = 32;
  localparam int unsigned IncW = 31;
  localparam int unsigned StampW = 20;
  localparam int unsigned EntryW = AddrW + IncW + 1 + StampW;

  localparam logic OpGossip = 1'b0;
  localparam logic OpJoin = 1'b1;
  localparam logic KindForward = 1'b0;
  localparam logic KindCopy = 1'b1;

  typedef struct packed {
    logic [AddrW-1:0]  addr;
    logic [IncW-1:0]   inc;
    logic              alive;
    logic [StampW-1:0] stamp;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load;      // capture the input beat
    logic            rd_en;     // read the table entry at idx
    logic [IdxW-1:0] idx;
    logic            search;    // compare the read entry with the node address
    logic            clr_hit;
    logic            update;    // write back the decided change
    logic            emit;      // present a result from the read entry
    logic            emit_kind;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic            hit;
    logic            changed;   // decision after the search
    logic            rd_alive;  // the entry just read is alive
    logic [CntW-1:0] count;
    logic            opcode;
  } stat_t;

endpackage

>>> rtl/mtu_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module mtu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/mtu_datapath.sv
// Datapath of the membership table update: message registers, table and result registers.
module mtu_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 opcode_i,
  input  logic [31:0]          node_addr_i,
  input  logic [30:0]          node_incarnation_i,
  input  logic                 node_alive_i,
  input  logic [19:0]          msg_stamp_i,
  input  logic [31:0]          sender_addr_i,
  input  logic [19:0]          now_stamp_i,
  input  mtu_pkg::ctrl_t       ctrl_i,
  output mtu_pkg::stat_t       stat_o,
  output logic                 send_kind_o,
  output logic [31:0]          dest_addr_o,
  output logic [31:0]          out_addr_o,
  output logic [30:0]          out_incarnation_o,
  output logic                 out_alive_o,
  output logic                 out_type_o,
  output logic [19:0]          out_stamp_o
);

  logic                      op_q;
  logic [31:0]               addr_q, sender_q;
  logic [30:0]               inc_q;
  logic                      alive_q;
  logic [19:0]               mstamp_q, now_q;
  logic                      hit_q, hit_d;
  logic [mtu_pkg::IdxW-1:0]  hidx_q, hidx_d;
  logic [mtu_pkg::IdxW-1:0]  ridx_q;
  mtu_pkg::entry_t           hent_q, hent_d;
  logic [mtu_pkg::CntW-1:0]  count_q, count_d;
  mtu_pkg::entry_t           rd_ent, wr_ent;
  logic [mtu_pkg::EntryW-1:0] rdata;
  logic                      changed, do_ins, we;
  logic [mtu_pkg::IdxW-1:0]  waddr;
  logic                      full;

  mtu_ram #(.Width(mtu_pkg::EntryW), .Depth(mtu_pkg::TableEntries)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wr_ent),
    .re_i   (ctrl_i.rd_en),
    .raddr_i(ctrl_i.idx),
    .rdata_o(rdata)
  );

  assign rd_ent = mtu_pkg::entry_t'(rdata);
  assign full = (count_q == mtu_pkg::CntW'(mtu_pkg::TableEntries));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q     <= opcode_i;
      addr_q   <= node_addr_i;
      inc_q    <= node_incarnation_i;
      alive_q  <= node_alive_i;
      mstamp_q <= msg_stamp_i;
      sender_q <= sender_addr_i;
      now_q    <= now_stamp_i;
    end
    // Slot index of the entry that the RAM presents in the following cycle.
    if (ctrl_i.rd_en) begin
      ridx_q <= ctrl_i.idx;
    end
    hidx_q <= hidx_d;
    hent_q <= hent_d;
  end

  always_comb begin
    hit_d  = hit_q;
    hidx_d = hidx_q;
    hent_d = hent_q;
    if (ctrl_i.clr_hit) begin
      hit_d = 1'b0;
    end else if (ctrl_i.search && !hit_q && rd_ent.addr == addr_q) begin
      hit_d  = 1'b1;
      hidx_d = ridx_q;
      hent_d = rd_ent;
    end
  end

  // Decision, taken once the search is complete.
  always_comb begin
    changed = 1'b0;
    do_ins  = 1'b0;
    wr_ent.addr  = addr_q;
    wr_ent.inc   = inc_q;
    wr_ent.alive = alive_q;
    wr_ent.stamp = now_q;
    if (op_q == mtu_pkg::OpGossip) begin
      if (hit_q) begin
        if (inc_q == hent_q.inc) begin
          changed = !alive_q && hent_q.alive;
        end else if (inc_q > hent_q.inc) begin
          changed = 1'b1;
        end
      end else if (alive_q && !full) begin
        changed = 1'b1;
        do_ins  = 1'b1;
      end
    end else begin
      changed = 1'b1;
      if (hit_q) begin
        wr_ent.alive = 1'b1;
      end else begin
        do_ins = !full;
        changed = !full;
      end
    end
  end

  assign we    = ctrl_i.update && changed;
  assign waddr = hit_q ? hidx_q : count_q[mtu_pkg::IdxW-1:0];

  always_comb begin
    count_d = count_q;
    if (ctrl_i.update && do_ins) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      send_kind_o <= ctrl_i.emit_kind;
      if (ctrl_i.emit_kind == mtu_pkg::KindForward) begin
        dest_addr_o       <= rd_ent.addr;
        out_addr_o        <= addr_q;
        out_incarnation_o <= inc_q;
        out_alive_o       <= alive_q;
        out_type_o        <= op_q;
        out_stamp_o       <= mstamp_q;
      end else begin
        dest_addr_o       <= sender_q;
        out_addr_o        <= rd_ent.addr;
        out_incarnation_o <= rd_ent.inc;
        out_alive_o       <= rd_ent.alive;
        out_type_o        <= mtu_pkg::OpGossip;
        out_stamp_o       <= rd_ent.stamp;
      end
    end
  end

  assign stat_o.hit      = hit_q;
  assign stat_o.changed  = changed;
  assign stat_o.rd_alive = rd_ent.alive;
  assign stat_o.count    = count_q;
  assign stat_o.opcode   = op_q;

endmodule

>>> rtl/mtu_ctrl.sv
// Controller state machine of the membership table update.
module mtu_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  output mtu_pkg::ctrl_t ctrl_o,
  input  mtu_pkg::stat_t stat_i,
  output logic           strobe_o,
  output logic           last_item_o
);

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StSearch = 7'b0000010,
    StDecide = 7'b0000100,
    StFwd    = 7'b0001000,
    StCopy   = 7'b0010000,
    StFlush  = 7'b0100000,
    StEnd    = 7'b1000000
  } state_e;

  state_e                   state_q, state_d;
  logic [mtu_pkg::CntW-1:0] ptr_q, ptr_d;     // next entry to read
  logic                     rdv_q, rdv_d;     // a read of entry ptr_q-1 is in flight
  logic                     pend_q, pend_d;   // a result register holds an unsent beat
  logic                     strobe_q, strobe_d;
  logic                     last_q, last_d;
  logic                     emit_now, pend_next;
  logic                     more_rd;

  assign busy_o      = (state_q != StIdle);
  assign strobe_o    = strobe_q;
  assign last_item_o = last_q;
  assign more_rd     = (ptr_q < stat_i.count);

  // Results are held one step in the result register, so that the last one can be
  // flagged once the scan has ended.
  always_comb begin
    state_d  = state_q;
    ptr_d    = ptr_q;
    rdv_d    = 1'b0;
    pend_d   = pend_q;
    strobe_d = 1'b0;
    last_d   = 1'b0;
    ctrl_o   = '0;
    ctrl_o.idx = ptr_q[mtu_pkg::IdxW-1:0];
    emit_now = 1'b0;
    pend_next = 1'b0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          ctrl_o.load    = 1'b1;
          ctrl_o.clr_hit = 1'b1;
          ptr_d   = '0;
          pend_d  = 1'b0;
          state_d = StSearch;
        end
      end
      StSearch: begin
        ctrl_o.search = rdv_q;
        if (more_rd) begin
          ctrl_o.rd_en = 1'b1;
          ptr_d = ptr_q + 1'b1;
          rdv_d = 1'b1;
        end else if (!rdv_q) begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        ctrl_o.update = 1'b1;
        ptr_d = '0;
        if (stat_i.changed || stat_i.opcode == mtu_pkg::OpJoin) begin
          state_d = StFwd;
        end else begin
          state_d = StEnd;
        end
      end
      StFwd, StCopy: begin
        if (rdv_q && (state_q == StCopy || stat_i.rd_alive)) begin
          emit_now = 1'b1;
          ctrl_o.emit = 1'b1;
          ctrl_o.emit_kind = (state_q == StCopy) ? mtu_pkg::KindCopy
                                                 : mtu_pkg::KindForward;
        end
        if (more_rd) begin
          ctrl_o.rd_en = 1'b1;
          ptr_d = ptr_q + 1'b1;
          rdv_d = 1'b1;
        end else if (!rdv_q) begin
          ptr_d = '0;
          if (state_q == StFwd && stat_i.opcode == mtu_pkg::OpJoin) begin
            state_d = StCopy;
          end else begin
            state_d = StFlush;
          end
        end
      end
      StFlush: begin
        strobe_d = pend_q;
        last_d   = pend_q;
        pend_d   = 1'b0;
        state_d  = StEnd;
      end
      StEnd: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    if (emit_now) begin
      pend_next = 1'b1;
    end
    if (emit_now) begin
      strobe_d = 1'b0;
      pend_d   = pend_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      ptr_q      <= '0;
      rdv_q      <= 1'b0;
      pend_q     <= 1'b0;
      strobe_q   <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      rdv_q      <= rdv_d;
      pend_q     <= pend_d;
      strobe_q   <= strobe_d;
      last_q     <= last_d;
    end
  end

endmodule

>>> rtl/membership_table_update_top.sv
// Top level of the membership table update block.
//
// Channel   Direction  Beat accepted when
// input     in         start high and busy low at a rising edge
// result    out        strobe_o high for one cycle; the receiver cannot stall
//
// An item first reads every filled slot, one a cycle, to find the node, then writes back
// the change. Forwards and table copies each take one more scan of the filled slots
// through the single RAM read port, so a join costs about three scans. Results leave
// through a one-beat holding stage so that the final beat carries last_item_o.
// Reset empties the table by clearing the fill count; no clearing pass is needed.
module membership_table_update_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [31:0] node_addr_i,
  input  logic [30:0] node_incarnation_i,
  input  logic        node_alive_i,
  input  logic [19:0] msg_stamp_i,
  input  logic [31:0] sender_addr_i,
  input  logic [19:0] now_stamp_i,
  output logic        strobe_o,
  output logic        send_kind_o,
  output logic [31:0] dest_addr_o,
  output logic [31:0] out_addr_o,
  output logic [30:0] out_incarnation_o,
  output logic        out_alive_o,
  output logic        out_type_o,
  output logic [19:0] out_stamp_o,
  output logic        last_item_o
);

  mtu_pkg::ctrl_t ctrl;
  mtu_pkg::stat_t stat;
  logic           emit_strobe, emit_last;

  // Raw beat from the datapath, held one stage here.
  logic        r_kind;
  logic [31:0] r_dest, r_addr;
  logic [30:0] r_inc;
  logic        r_alive, r_type;
  logic [19:0] r_stamp;
  logic        hold_q;

  mtu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_o     (busy),
    .ctrl_o     (ctrl),
    .stat_i     (stat),
    .strobe_o   (emit_strobe),
    .last_item_o(emit_last)
  );

  mtu_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .opcode_i          (opcode_i),
    .node_addr_i       (node_addr_i),
    .node_incarnation_i(node_incarnation_i),
    .node_alive_i      (node_alive_i),
    .msg_stamp_i       (msg_stamp_i),
    .sender_addr_i     (sender_addr_i),
    .now_stamp_i       (now_stamp_i),
    .ctrl_i            (ctrl),
    .stat_o            (stat),
    .send_kind_o       (r_kind),
    .dest_addr_o       (r_dest),
    .out_addr_o        (r_addr),
    .out_incarnation_o (r_inc),
    .out_alive_o       (r_alive),
    .out_type_o        (r_type),
    .out_stamp_o       (r_stamp)
  );

  // The datapath result register is loaded by each emit command. When a
  // newer beat is about to be loaded while an older one is held, the older one is
  // copied out as a non-final beat; the controller flush sends the final one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q      <= 1'b0;
      strobe_o    <= 1'b0;
      last_item_o <= 1'b0;
    end else begin
      strobe_o    <= (ctrl.emit && hold_q) || emit_strobe;
      last_item_o <= emit_last && !(ctrl.emit && hold_q);
      if (ctrl.load) begin
        hold_q <= 1'b0;
      end else if (ctrl.emit) begin
        hold_q <= 1'b1;
      end else if (emit_strobe) begin
        hold_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((ctrl.emit && hold_q) || emit_strobe) begin
      send_kind_o       <= r_kind;
      dest_addr_o       <= r_dest;
      out_addr_o        <= r_addr;
      out_incarnation_o <= r_inc;
      out_alive_o       <= r_alive;
      out_type_o        <= r_type;
      out_stamp_o       <= r_stamp;
    end
  end

endmodule

>>> sim/tb_membership_table_update_top.sv
// Self-checking testbench for the membership table update block.
`timescale 1ns / 1ps

module tb_membership_table_update_top;

  // One outgoing message as the block presents it on the result ports.
  typedef struct packed {
    logic        kind;
    logic [31:0] dest;
    logic [31:0] addr;
    logic [30:0] inc;
    logic        alive;
    logic        mtype;
    logic [19:0] stamp;
    logic        last;
  } send_t;

  // One incoming membership message with the local time.
  typedef struct packed {
    logic        op;
    logic [31:0] addr;
    logic [30:0] inc;
    logic        alive;
    logic [19:0] mstamp;
    logic [31:0] sender;
    logic [19:0] now;
  } msg_t;

  // A row of the directed table. Where has_first is set, the first send of the
  // row is also typed in by hand and compared with what the predictor gives.
  typedef struct packed {
    msg_t  msg;
    logic  has_first;
    send_t first;
  } row_t;

  localparam int unsigned WatchdogLimit = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        opcode_i = mtu_pkg::OpGossip;
  logic [31:0] node_addr_i = '0;
  logic [30:0] node_incarnation_i = '0;
  logic        node_alive_i = 1'b0;
  logic [19:0] msg_stamp_i = '0;
  logic [31:0] sender_addr_i = '0;
  logic [19:0] now_stamp_i = '0;
  logic        strobe_o;
  logic        send_kind_o;
  logic [31:0] dest_addr_o;
  logic [31:0] out_addr_o;
  logic [30:0] out_incarnation_o;
  logic        out_alive_o;
  logic        out_type_o;
  logic [19:0] out_stamp_o;
  logic        last_item_o;

  always #5 clk_i = ~clk_i;

  membership_table_update_top i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .opcode_i          (opcode_i),
    .node_addr_i       (node_addr_i),
    .node_incarnation_i(node_incarnation_i),
    .node_alive_i      (node_alive_i),
    .msg_stamp_i       (msg_stamp_i),
    .sender_addr_i     (sender_addr_i),
    .now_stamp_i       (now_stamp_i),
    .strobe_o          (strobe_o),
    .send_kind_o       (send_kind_o),
    .dest_addr_o       (dest_addr_o),
    .out_addr_o        (out_addr_o),
    .out_incarnation_o (out_incarnation_o),
    .out_alive_o       (out_alive_o),
    .out_type_o        (out_type_o),
    .out_stamp_o       (out_stamp_o),
    .last_item_o       (last_item_o)
  );

  // The testbench's own copy of the membership table. Slots fill in order and
  // are never freed, so a fill count alone says which slots hold a node.
  logic [31:0] tbl_addr  [mtu_pkg::TableEntries];
  logic [30:0] tbl_inc   [mtu_pkg::TableEntries];
  logic        tbl_alive [mtu_pkg::TableEntries];
  logic [19:0] tbl_stamp [mtu_pkg::TableEntries];
  int unsigned tbl_fill;

  send_t pending_sends[$];
  row_t  rows[$];
  int    mismatches;
  int    cycles_idle;
  bit    drained;
  bit    no_gaps;

  // Addresses of nodes that have been offered, so that random messages can
  // revisit known nodes rather than only ever miss the table.
  logic [31:0] seen_addrs[$];

  // Applies one message to the table copy and returns the sends it causes, in
  // the order the block produces them: forwards to alive slots in slot order,
  // then, for a join, a copy of every filled slot to the sender.
  function automatic void predict_sends(input msg_t m, output send_t sends[$]);
    int    hit;
    bit    changed;
    send_t s;
    sends = {};
    hit = -1;
    changed = 1'b0;
    for (int i = 0; i < tbl_fill; i++) begin
      if (hit < 0 && tbl_addr[i] == m.addr) hit = i;
    end
    if (m.op == mtu_pkg::OpGossip) begin
      if (hit >= 0) begin
        if (m.inc == tbl_inc[hit]) begin
          // Equal incarnation only ever turns an alive node dead.
          if (!m.alive && tbl_alive[hit]) begin
            tbl_alive[hit] = 1'b0;
            tbl_stamp[hit] = m.now;
            changed = 1'b1;
          end
        end else if (m.inc > tbl_inc[hit]) begin
          tbl_inc[hit] = m.inc;
          tbl_alive[hit] = m.alive;
          tbl_stamp[hit] = m.now;
          changed = 1'b1;
        end
      end else if (m.alive && tbl_fill < mtu_pkg::TableEntries) begin
        tbl_addr[tbl_fill] = m.addr;
        tbl_inc[tbl_fill] = m.inc;
        tbl_alive[tbl_fill] = 1'b1;
        tbl_stamp[tbl_fill] = m.now;
        tbl_fill++;
        changed = 1'b1;
      end
    end else begin
      if (hit >= 0) begin
        tbl_alive[hit] = 1'b1;
        tbl_inc[hit] = m.inc;
        tbl_stamp[hit] = m.now;
      end else if (tbl_fill < mtu_pkg::TableEntries) begin
        tbl_addr[tbl_fill] = m.addr;
        tbl_inc[tbl_fill] = m.inc;
        tbl_alive[tbl_fill] = m.alive;
        tbl_stamp[tbl_fill] = m.now;
        tbl_fill++;
      end
      // A join always forwards, even when the table is full.
      changed = 1'b1;
    end
    if (changed) begin
      for (int i = 0; i < tbl_fill; i++) begin
        if (tbl_alive[i]) begin
          s = '{mtu_pkg::KindForward, tbl_addr[i], m.addr, m.inc, m.alive, m.op, m.mstamp,
                1'b0};
          sends = {sends, s};
        end
      end
    end
    if (m.op == mtu_pkg::OpJoin) begin
      for (int i = 0; i < tbl_fill; i++) begin
        s = '{mtu_pkg::KindCopy, m.sender, tbl_addr[i], tbl_inc[i], tbl_alive[i],
              mtu_pkg::OpGossip, tbl_stamp[i], 1'b0};
        sends = {sends, s};
      end
    end
    if (sends.size() > 0) sends[sends.size()-1].last = 1'b1;
  endfunction

  function automatic void add_row(input msg_t msg, input logic has_first, input send_t first);
    row_t row;
    row.msg = msg;
    row.has_first = has_first;
    row.first = first;
    rows = {rows, row};
  endfunction

  task automatic report_mismatch(input string what, input send_t exp_s, input send_t act_s);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected kind=%0b dest=%h addr=%h inc=%h alive=%0b type=%0b",
               what, exp_s.kind, exp_s.dest, exp_s.addr, exp_s.inc, exp_s.alive, exp_s.mtype);
      $display("  stamp=%h last=%0b; actual kind=%0b dest=%h addr=%h inc=%h alive=%0b",
               exp_s.stamp, exp_s.last, act_s.kind, act_s.dest, act_s.addr, act_s.inc,
               act_s.alive);
      $display("  type=%0b stamp=%h last=%0b", act_s.mtype, act_s.stamp, act_s.last);
    end
  endtask

  // Result side. The receiver cannot stall, so every strobed beat is taken
  // at the edge that ends its cycle and compared with the oldest expectation.
  always @(posedge clk_i) begin
    send_t act_s;
    send_t exp_s;
    if (rst_ni && strobe_o) begin
      act_s = '{send_kind_o, dest_addr_o, out_addr_o, out_incarnation_o, out_alive_o,
                out_type_o, out_stamp_o, last_item_o};
      if (pending_sends.size() == 0) begin
        report_mismatch("unexpected beat", '0, act_s);
      end else begin
        exp_s = pending_sends.pop_front();
        if (act_s !== exp_s) report_mismatch("field", exp_s, act_s);
      end
    end
  end

  // Watchdog: counts cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || strobe_o || (start && !busy)) begin
      cycles_idle <= 0;
    end else if (!drained) begin
      cycles_idle <= cycles_idle + 1;
      if (cycles_idle >= WatchdogLimit) begin
        $display("membership_table_update_top regression: fail");
        $finish;
      end
    end
  end

  // Drives one message and waits for its beat to be accepted. Before it, a
  // random burst of idle cycles is sometimes inserted unless the gap-free stretch runs.
  task automatic send_msg(input msg_t m, output send_t sends[$]);
    @(posedge clk_i);
    if (!no_gaps && $urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    start <= 1'b1;
    opcode_i <= m.op;
    node_addr_i <= m.addr;
    node_incarnation_i <= m.inc;
    node_alive_i <= m.alive;
    msg_stamp_i <= m.mstamp;
    sender_addr_i <= m.sender;
    now_stamp_i <= m.now;
    do @(posedge clk_i); while (busy);
    start <= 1'b0;
    // The beat is taken at this edge; predict now so the expectations are in
    // place before the first result can appear.
    predict_sends(m, sends);
    pending_sends = {pending_sends, sends};
    seen_addrs = {seen_addrs, m.addr};
  endtask

  function automatic msg_t random_msg();
    msg_t m;
    m.op = $urandom_range(0, 3) == 0 ? mtu_pkg::OpJoin : mtu_pkg::OpGossip;
    // Mostly revisit known nodes so that the incarnation rules get exercised.
    if (seen_addrs.size() > 0 && $urandom_range(0, 3) != 0)
      m.addr = seen_addrs[$urandom_range(0, seen_addrs.size() - 1)];
    else
      m.addr = $urandom();
    case ($urandom_range(0, 3))
      0: m.inc = 31'($urandom_range(0, 3));
      1: m.inc = 31'(32'h7FFF_FFFF - $urandom_range(0, 3));
      default: m.inc = 31'($urandom());
    endcase
    m.alive = 1'($urandom_range(0, 1));
    m.mstamp = 20'($urandom_range(0, 999999));
    m.sender = $urandom();
    m.now = 20'($urandom_range(0, 999999));
    return m;
  endfunction

  initial begin
    msg_t  m;
    send_t got[$];

    mismatches = 0;
    cycles_idle = 0;
    drained = 1'b0;
    no_gaps = 1'b0;
    tbl_fill = 0;

    // Directed rows. Expectations typed in where the outcome is plain.
    // Unknown failed node on an empty table: ignored.
    add_row('{mtu_pkg::OpGossip, 32'hFFFF_FFFF, 31'h0, 1'b0, 20'd0, 32'h0, 20'd0},
            1'b0, '0);
    // First alive gossip: inserted, but nobody alive yet except itself.
    add_row('{mtu_pkg::OpGossip, 32'h0000_0000, 31'h0, 1'b1, 20'd999999, 32'h1, 20'd7},
            1'b1, '{mtu_pkg::KindForward, 32'h0, 32'h0, 31'h0, 1'b1, mtu_pkg::OpGossip,
            20'd999999, 1'b1});
    // Join of a new node with the widest fields.
    add_row('{mtu_pkg::OpJoin, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 20'd0, 32'hFFFF_FFFF,
            20'd999999}, 1'b1, '{mtu_pkg::KindForward, 32'h0, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
            1'b1, mtu_pkg::OpJoin, 20'd0, 1'b0});
    // Older incarnation dropped; equal incarnation alive is no change.
    add_row('{mtu_pkg::OpGossip, 32'hFFFF_FFFF, 31'h7FFF_FFFE, 1'b0, 20'd5, 32'h2, 20'd5},
            1'b0, '0);
    add_row('{mtu_pkg::OpGossip, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 20'd5, 32'h2, 20'd5},
            1'b0, '0);
    // Equal incarnation, failed: the node is marked dead.
    add_row('{mtu_pkg::OpGossip, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0, 20'd6, 32'h2, 20'd9},
            1'b0, '0);
    // Newer incarnation overwrites.
    add_row('{mtu_pkg::OpGossip, 32'h0000_0000, 31'h5, 1'b0, 20'd11, 32'h3, 20'd12},
            1'b0, '0);
    // Join revives a dead node; join of an unknown failed node.
    add_row('{mtu_pkg::OpJoin, 32'h0000_0000, 31'h1, 1'b0, 20'd13, 32'h5555_5555, 20'd14},
            1'b0, '0);
    add_row('{mtu_pkg::OpJoin, 32'hAAAA_AAAA, 31'h2AAA_AAAA, 1'b0, 20'hAAAAA, 32'h5,
            20'h55555}, 1'b0, '0);
    // Fill the table with alive nodes so that later inserts hit a full table.
    for (int i = 0; i < 14; i++)
      add_row('{mtu_pkg::OpGossip, 32'h1000_0000 + i, 31'(i), 1'b1, 20'(i), 32'h7, 20'(i)},
              1'b0, '0);
    // Full table: gossip insert dropped, join still forwards and copies.
    add_row('{mtu_pkg::OpGossip, 32'h2000_0000, 31'h1, 1'b1, 20'd1, 32'h7, 20'd1},
            1'b0, '0);
    add_row('{mtu_pkg::OpJoin, 32'h2000_0001, 31'h1, 1'b1, 20'd1, 32'h8, 20'd2},
            1'b0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) begin
      send_msg(rows[r].msg, got);
      if (rows[r].has_first && (got.size() == 0 || got[0] !== rows[r].first))
        report_mismatch("hand expectation", rows[r].first, got.size() ? got[0] : '0);
    end

    // Random part. The table is never cleared and is already full after the directed
    // rows, so the run mostly exercises the full-table behaviour.
    for (int n = 0; n < 256; n++) begin
      no_gaps = (n >= 216);
      m = random_msg();
      send_msg(m, got);
      if (!no_gaps && $urandom_range(0, 1)) wait (pending_sends.size() == 0);
    end

    wait (pending_sends.size() == 0);
    drained = 1'b1;
    repeat (80) @(posedge clk_i);
    if (mismatches == 0 && pending_sends.size() == 0) begin
      $display("membership_table_update_top regression: pass");
    end else begin
      $display("membership_table_update_top regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/mtu_pkg.sv
rtl/mtu_ram.sv
rtl/mtu_datapath.sv
rtl/mtu_ctrl.sv
rtl/membership_table_update_top.sv
sim/tb_membership_table_update_top.sv
